/* rtl/fir_ch_pkg.sv */
package fir_ch_pkg;

  localparam int DEF_MAX_TAPS     = 64;
  localparam int DEF_SAMPLE_WIDTH = 16;

  localparam int FUNC_W      = 2;
  localparam int COEF_IDX_W  = 6;
  localparam int TAP_COUNT_W = 7;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [FUNC_W-1:0] FUNC_FILTER = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 7'd64;

  // register index, taken from paddr above the byte offset
  localparam logic [CFG_ADDR_W-3:0] REG_TAP_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } fir_ch_state_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic start;
    logic load;
    logic flush;
    logic shift;
  } fir_ch_ctrl_t;

endpackage

/* rtl/fir_filter_circular_history_core.sv */
// channel  dir  handshake             payload
// in_      in   in_tvalid/in_tready   tuser: func; tdata: sample, coef_index, coef_value
// out_     out  out_tvalid/out_tready tuser: saturated; tdata: filtered
// cfg_     in   apb, pready tied high register 0 tap_count at byte address 0
//
// in a filter item the coefficient ring rotates once through all MAX_TAPS
// cells, then the multiply and accumulate stages drain and the result is
// rounded; load and flush act on the transfer and leave the block idle.
// reset clears history, coefficients and write position, tap_count = 64.
// a result waits in the output register while the next item is taken; only a
// finished result that finds the register still full holds the block.
module fir_filter_circular_history_core #(
  parameter int MAX_TAPS     = fir_ch_pkg::DEF_MAX_TAPS,
  parameter int SAMPLE_WIDTH = fir_ch_pkg::DEF_SAMPLE_WIDTH,
  localparam int IN_BITS = 2 * SAMPLE_WIDTH + fir_ch_pkg::COEF_IDX_W,
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_W   = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [IN_W-1:0]                      in_tdata,   // sample, coef_index, coef_value
  input  logic [fir_ch_pkg::FUNC_W-1:0]        in_tuser,   // func
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [OUT_W-1:0]                     out_tdata,  // filtered
  output logic                                 out_tuser,  // saturated
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [fir_ch_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [fir_ch_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [fir_ch_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int PW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TW   = $clog2(MAX_TAPS + 1);
  localparam int CW   = PW;
  localparam int TCW  = fir_ch_pkg::TAP_COUNT_W;
  localparam int CMPW = (TW > TCW) ? TW : TCW;
  localparam int SW   = SAMPLE_WIDTH;
  localparam int IW   = fir_ch_pkg::COEF_IDX_W;

  fir_ch_pkg::fir_ch_state_t state_r, state_nxt;
  fir_ch_pkg::fir_ch_ctrl_t  ctrl;

  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [PW-1:0]             wp_r, wp_nxt;
  logic [TCW-1:0]            tap_count_r;
  logic [TW-1:0]             taps;
  logic [PW:0]               wp_inc;
  logic                      in_xfer;
  logic                      cfg_wr;
  logic                      mac_clr;
  logic                      mac_vld;
  logic                      out_load;
  logic                      out_free;
  logic                      out_tvalid_r;
  logic signed [SW-1:0]      out_data_r;
  logic                      out_sat_r;
  logic signed [SW-1:0]      mac_res;
  logic                      mac_sat;

  logic signed [SW-1:0]      in_sample;
  logic [IW-1:0]             in_coef_idx;
  logic signed [SW-1:0]      in_coef_val;
  logic [fir_ch_pkg::FUNC_W-1:0] in_func;

  logic [MAX_TAPS-1:0]       tok_vec;
  logic signed [SW-1:0]      coef_vec [MAX_TAPS];
  logic signed [SW-1:0]      rd_vec   [MAX_TAPS];
  logic signed [SW-1:0]      hist_bus;

  assign in_sample   = in_tdata[SW-1:0];
  assign in_coef_idx = in_tdata[SW+IW-1:SW];
  assign in_coef_val = in_tdata[2*SW+IW-1:SW+IW];
  assign in_func     = in_tuser;

  assign in_tready = (state_r == fir_ch_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[fir_ch_pkg::CFG_ADDR_W-1:2] == fir_ch_pkg::REG_TAP_COUNT) ?
                      fir_ch_pkg::CFG_DATA_W'(tap_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= fir_ch_pkg::TAP_COUNT_RST;
    end else if (cfg_wr &&
                 cfg_paddr[fir_ch_pkg::CFG_ADDR_W-1:2] == fir_ch_pkg::REG_TAP_COUNT) begin
      tap_count_r <= cfg_pwdata[TCW-1:0];
    end
  end

  always_comb begin
    if (tap_count_r == '0) begin
      taps = TW'(1);
    end else if (CMPW'(tap_count_r) > CMPW'(MAX_TAPS)) begin
      taps = TW'(MAX_TAPS);
    end else begin
      taps = TW'(tap_count_r);
    end
  end

  assign wp_inc   = {1'b0, wp_r} + (PW + 1)'(1);
  assign out_free = !out_tvalid_r || out_tready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    wp_nxt    = wp_r;
    ctrl      = '0;
    mac_clr   = 1'b0;
    mac_vld   = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      fir_ch_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_func)
            fir_ch_pkg::FUNC_FILTER: begin
              ctrl.start = 1'b1;
              mac_clr    = 1'b1;
              cnt_nxt    = '0;
              state_nxt  = fir_ch_pkg::ST_RUN;
              wp_nxt     = (wp_inc >= (PW + 1)'(taps)) ? '0 : wp_inc[PW-1:0];
            end
            fir_ch_pkg::FUNC_LOAD: begin
              ctrl.load = 1'b1;
            end
            fir_ch_pkg::FUNC_FLUSH: begin
              ctrl.flush = 1'b1;
              wp_nxt     = '0;
            end
            default: begin
            end
          endcase
        end
      end
      fir_ch_pkg::ST_RUN: begin
        ctrl.shift = 1'b1;
        mac_vld    = (TW'(cnt_r) < taps);
        if (cnt_r == CW'(MAX_TAPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = fir_ch_pkg::ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      fir_ch_pkg::ST_DRAIN: begin
        if (cnt_r == CW'(1)) begin
          state_nxt = fir_ch_pkg::ST_DONE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      fir_ch_pkg::ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = fir_ch_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fir_ch_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fir_ch_pkg::ST_IDLE;
      cnt_r   <= '0;
      wp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      wp_r    <= wp_nxt;
    end
  end

  // cell row
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    localparam int NXT = (k + 1) % MAX_TAPS;
    logic tok_in;

    if (k == MAX_TAPS - 1) begin : g_last
      assign tok_in = 1'b0;
    end else begin : g_mid
      assign tok_in = tok_vec[k+1];
    end

    fir_ch_cell #(
      .MAX_TAPS     (MAX_TAPS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .K            (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .sample   (in_sample),
      .pos      (wp_r),
      .ld_idx   (in_coef_idx),
      .ld_val   (in_coef_val),
      .taps     (taps),
      .coef_in  (coef_vec[NXT]),
      .tok_in   (tok_in),
      .tok_wrap (tok_vec[0]),
      .coef_out (coef_vec[k]),
      .tok_out  (tok_vec[k]),
      .rd_out   (rd_vec[k])
    );
  end

  always_comb begin
    hist_bus = '0;
    for (int k = 0; k < MAX_TAPS; k++) begin
      hist_bus = hist_bus | rd_vec[k];
    end
  end

  fir_ch_mac #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (mac_clr),
    .vld    (mac_vld),
    .hist   (hist_bus),
    .coef   (coef_vec[0]),
    .result (mac_res),
    .sat    (mac_sat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= mac_res;
      out_sat_r  <= mac_sat;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'(unsigned'(out_data_r));
  assign out_tuser  = out_sat_r;

  // checks
  a_tok_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one read token in the cell row");

  a_tok_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fir_ch_pkg::ST_RUN && cnt_r == '0) |-> $onehot(tok_vec))
    else $error("no read token at the start of a filter pass");

  a_filter_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_func == fir_ch_pkg::FUNC_FILTER) |=> (state_r == fir_ch_pkg::ST_RUN))
    else $error("filter transfer did not start a pass");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == fir_ch_pkg::ST_DONE))
    else $error("result raised outside the finish step");

endmodule

/* rtl/fir_ch_cell.sv */
module fir_ch_cell #(
  parameter int MAX_TAPS     = fir_ch_pkg::DEF_MAX_TAPS,
  parameter int SAMPLE_WIDTH = fir_ch_pkg::DEF_SAMPLE_WIDTH,
  parameter int K            = 0,
  localparam int PW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
  localparam int TW = $clog2(MAX_TAPS + 1)
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  fir_ch_pkg::fir_ch_ctrl_t               ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample,
  input  logic [PW-1:0]                          pos,
  input  logic [fir_ch_pkg::COEF_IDX_W-1:0]      ld_idx,
  input  logic signed [SAMPLE_WIDTH-1:0]         ld_val,
  input  logic [TW-1:0]                          taps,
  input  logic signed [SAMPLE_WIDTH-1:0]         coef_in,
  input  logic                                   tok_in,
  input  logic                                   tok_wrap,
  output logic signed [SAMPLE_WIDTH-1:0]         coef_out,
  output logic                                   tok_out,
  output logic signed [SAMPLE_WIDTH-1:0]         rd_out
);

  logic signed [SAMPLE_WIDTH-1:0] hist_r;
  logic signed [SAMPLE_WIDTH-1:0] coef_r;
  logic                           tok_r;
  logic                           idx_hit;
  logic                           pos_hit;
  logic                           wrap_hit;

  // coefficient index reduced modulo the cell count
  always_comb begin
    idx_hit = 1'b0;
    for (int m = 0; m < (1 << fir_ch_pkg::COEF_IDX_W); m++) begin
      if ((m % MAX_TAPS) == K && ld_idx == fir_ch_pkg::COEF_IDX_W'(m)) begin
        idx_hit = 1'b1;
      end
    end
  end

  assign pos_hit  = (pos == PW'(K));
  assign wrap_hit = (taps == TW'(K + 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (ctrl.flush) begin
      hist_r <= '0;
    end else if (ctrl.start && pos_hit) begin
      hist_r <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (ctrl.load && idx_hit) begin
      coef_r <= ld_val;
    end else if (ctrl.shift) begin
      coef_r <= coef_in;
    end
  end

  // read token walks down and wraps from cell 0 to the last tap in use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else if (ctrl.start) begin
      tok_r <= pos_hit;
    end else if (ctrl.shift) begin
      tok_r <= tok_in | (wrap_hit & tok_wrap);
    end
  end

  assign coef_out = coef_r;
  assign tok_out  = tok_r;
  assign rd_out   = tok_r ? hist_r : '0;

endmodule

/* rtl/fir_ch_mac.sv */
module fir_ch_mac #(
  parameter int MAX_TAPS     = fir_ch_pkg::DEF_MAX_TAPS,
  parameter int SAMPLE_WIDTH = fir_ch_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           clr,
  input  logic                           vld,
  input  logic signed [SAMPLE_WIDTH-1:0] hist,
  input  logic signed [SAMPLE_WIDTH-1:0] coef,
  output logic signed [SAMPLE_WIDTH-1:0] result,
  output logic                           sat
);

  localparam int PROD_W   = 2 * SAMPLE_WIDTH;
  localparam int ACC_FULL = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;
  localparam int FRAC     = SAMPLE_WIDTH - 1;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] MAXV = (ACC_W'(1) << FRAC) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] MINV = ~MAXV;

  logic signed [SAMPLE_WIDTH-1:0] a_r;
  logic signed [SAMPLE_WIDTH-1:0] b_r;
  logic                           v_r;
  logic signed [PROD_W-1:0]       p_r;
  logic                           pv_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [ACC_W-1:0]        rnd;
  logic signed [ACC_W-1:0]        sh;

  always_ff @(posedge clk) begin
    a_r <= hist;
    b_r <= coef;
    p_r <= a_r * b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      pv_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      v_r  <= vld;
      pv_r <= v_r;
      if (clr) begin
        acc_r <= '0;
      end else if (pv_r) begin
        acc_r <= acc_r + ACC_W'(p_r);
      end
    end
  end

  // round half up, then clip to the sample range
  always_comb begin
    rnd = acc_r + HALF;
    sh  = rnd >>> FRAC;
    if (sh > MAXV) begin
      result = MAXV[SAMPLE_WIDTH-1:0];
      sat    = 1'b1;
    end else if (sh < MINV) begin
      result = MINV[SAMPLE_WIDTH-1:0];
      sat    = 1'b1;
    end else begin
      result = sh[SAMPLE_WIDTH-1:0];
      sat    = 1'b0;
    end
  end

endmodule
